// ----- sv/uart_rx_oversampled_parity_unit_assert.svh -----
// ----------------------------------------------------------------------------
// UART receiver assertion macros
// Property templates for the checker of the receiver.
// ----------------------------------------------------------------------------
`ifndef UART_RX_OVERSAMPLED_PARITY_UNIT_ASSERT_SVH
`define UART_RX_OVERSAMPLED_PARITY_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while rst is high.
`define URXOP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while rst is high.
`define URXOP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/uart_rxop_pkg.sv -----
// ----------------------------------------------------------------------------
// UART receiver package
// Frame geometry, parity codes and shared types of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package uart_rxop_pkg;

   // Frame geometry.
   localparam int TICKS_PER_BIT      = 3;
   localparam int DATA_BITS          = 8;
   localparam int FIRST_SAMPLE_TICKS = TICKS_PER_BIT + TICKS_PER_BIT / 2;

   // Derived widths.
   localparam int TICK_W = $clog2(FIRST_SAMPLE_TICKS + 1);
   localparam int BITS_W = $clog2(DATA_BITS + 2);
   localparam int SEL_W  = DATA_BITS + 1;
   localparam int BYTE_W = 8;
   localparam int MODE_W = 2;

   // Output buffer depth (a power of two).
   localparam int OUTBUF_DEPTH = 2;
   localparam int PTR_W        = $clog2(OUTBUF_DEPTH);
   localparam int CNT_W        = $clog2(OUTBUF_DEPTH + 1);

   // Parity mode codes; the unused code behaves as no parity.
   localparam logic [MODE_W-1:0] PARITY_NONE = 2'd0;
   localparam logic [MODE_W-1:0] PARITY_EVEN = 2'd1;
   localparam logic [MODE_W-1:0] PARITY_ODD  = 2'd2;

   typedef logic [BYTE_W-1:0] byte_type;

   // One finished frame leaving the frame engine.
   typedef struct packed {
      logic     valid;
      byte_type data;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/uart_rxop_if.sv -----
// ----------------------------------------------------------------------------
// UART receiver channel interfaces
// Valid/ready channels for line samples in and received bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

// Line sample channel: one item is one oversampling tick.
interface uart_rxop_req_if;
   logic valid;
   logic ready;
   logic line_level;

   modport source (output valid, output line_level, input ready);
   modport sink   (input valid, input line_level, output ready);
endinterface

// Received byte channel.
interface uart_rxop_rsp_if;
   logic                        valid;
   logic                        ready;
   uart_rxop_pkg::byte_type     received_byte;

   modport source (output valid, output received_byte, input ready);
   modport sink   (input valid, input received_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/uart_rx_oversampled_parity_unit.sv -----
// ----------------------------------------------------------------------------
// UART receiver with oversampling and parity check
// Top level: sample register, frame engine and output buffer.
// ----------------------------------------------------------------------------
// Each item on req_if is one line sample taken at three ticks per bit, and
// one item is taken every clock cycle while req_if.ready is high. An item
// is held in the sample register, the frame engine then updates its
// counters and shift register, and a completed byte enters a two-entry
// output buffer, from which it is offered on rsp_if.
// The only stall comes from that buffer: req_if.ready drops while the
// queued bytes and the sample in flight would fill it. Frames with a bad
// parity are dropped without notice, a low stop sample makes the receiver
// wait one more bit period, and parity_mode is latched at each start bit.
`default_nettype none

module uart_rx_oversampled_parity_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   uart_rxop_req_if.sink                          req_if,
   uart_rxop_rsp_if.source                        rsp_if,
   input  wire logic                              csr_write_enable,
   input  wire logic [uart_rxop_pkg::MODE_W-1:0]  csr_write_data
);

   localparam logic [uart_rxop_pkg::CNT_W:0] DEPTH_LIMIT =
      (uart_rxop_pkg::CNT_W + 1)'(uart_rxop_pkg::OUTBUF_DEPTH);

   logic [uart_rxop_pkg::MODE_W-1:0]   csr_parity_mode_ff;
   logic                               sample_valid_ff;
   logic                               sample_level_ff;
   logic [uart_rxop_pkg::CNT_W-1:0]    outbuf_count;
   logic [uart_rxop_pkg::CNT_W:0]      occupancy;
   uart_rxop_pkg::result_type          frame_result;

   // Take an item only when the buffer has room for every byte in flight.
   assign occupancy    = {1'b0, outbuf_count} +
                         (uart_rxop_pkg::CNT_W + 1)'(sample_valid_ff);
   assign req_if.ready = (occupancy < DEPTH_LIMIT);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_parity_mode_ff <= uart_rxop_pkg::PARITY_NONE;
      end else if (csr_write_enable) begin
         csr_parity_mode_ff <= csr_write_data;
      end
   end

   // Sample register in front of the frame engine.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
      end else begin
         sample_valid_ff <= req_if.valid && req_if.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         sample_level_ff <= req_if.line_level;
      end
   end

   uart_rxop_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (sample_valid_ff),
      .step_level  (sample_level_ff),
      .parity_mode (csr_parity_mode_ff),
      .result      (frame_result)
   );

   uart_rxop_outbuf u_outbuf (
      .clock (clock),
      .reset (reset),
      .push  (frame_result),
      .count (outbuf_count),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire

// ----- sv/uart_rxop_frame.sv -----
// ----------------------------------------------------------------------------
// UART receiver frame engine
// Tracks start, data, parity and stop sampling, one line tick per valid cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rxop_frame (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step_valid,
   input  wire logic                              step_level,
   input  wire logic [uart_rxop_pkg::MODE_W-1:0]  parity_mode,
   output uart_rxop_pkg::result_type              result
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_STOP = 2'd2
   } phase_type;

   localparam logic [uart_rxop_pkg::TICK_W-1:0] TICK_ONE =
      uart_rxop_pkg::TICK_W'(1);
   localparam logic [uart_rxop_pkg::TICK_W-1:0] TICK_RELOAD =
      uart_rxop_pkg::TICK_W'(uart_rxop_pkg::TICKS_PER_BIT);
   localparam logic [uart_rxop_pkg::TICK_W-1:0] TICK_FIRST =
      uart_rxop_pkg::TICK_W'(uart_rxop_pkg::FIRST_SAMPLE_TICKS);
   localparam logic [uart_rxop_pkg::BITS_W-1:0] BITS_ONE =
      uart_rxop_pkg::BITS_W'(1);
   localparam logic [uart_rxop_pkg::BITS_W-1:0] BITS_DATA =
      uart_rxop_pkg::BITS_W'(uart_rxop_pkg::DATA_BITS);

   phase_type                                  phase_ff, phase_in;
   logic [uart_rxop_pkg::TICK_W-1:0]           tick_count_ff, tick_count_in;
   logic [uart_rxop_pkg::BITS_W-1:0]           bits_left_ff, bits_left_in;
   logic [uart_rxop_pkg::DATA_BITS-1:0]        shift_data_ff, shift_data_in;
   logic [uart_rxop_pkg::SEL_W-1:0]            bit_select_ff, bit_select_in;
   logic                                       parity_acc_ff, parity_acc_in;
   logic                                       par_check_ff, par_check_in;
   logic                                       sample_now;
   logic                                       check_on;

   // A sample is due when the tick counter is about to reach zero.
   assign sample_now = (tick_count_ff == TICK_ONE);
   assign check_on   = (parity_mode == uart_rxop_pkg::PARITY_EVEN) ||
                       (parity_mode == uart_rxop_pkg::PARITY_ODD);

   // Next state of the frame for the current line tick.
   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      bits_left_in  = bits_left_ff;
      shift_data_in = shift_data_ff;
      bit_select_in = bit_select_ff;
      parity_acc_in = parity_acc_ff;
      par_check_in  = par_check_ff;
      result.valid  = 1'b0;
      result.data   = uart_rxop_pkg::BYTE_W'(shift_data_ff);
      if (step_valid) begin
         unique case (phase_ff)
            PH_DATA: begin
               tick_count_in = tick_count_ff - TICK_ONE;
               if (sample_now) begin
                  tick_count_in = TICK_RELOAD;
                  if (step_level) begin
                     shift_data_in =
                        shift_data_ff | bit_select_ff[uart_rxop_pkg::DATA_BITS-1:0];
                     parity_acc_in = ~parity_acc_ff;
                  end
                  bit_select_in = bit_select_ff << 1;
                  bits_left_in  = bits_left_ff - BITS_ONE;
                  if (bits_left_ff == BITS_ONE) begin
                     phase_in = PH_STOP;
                  end
               end
            end
            PH_STOP: begin
               tick_count_in = tick_count_ff - TICK_ONE;
               if (sample_now) begin
                  tick_count_in = TICK_RELOAD;
                  // A low stop level waits another bit period.
                  if (step_level) begin
                     phase_in     = PH_IDLE;
                     result.valid = !(par_check_ff && parity_acc_ff);
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               // A low level is the start bit; frame settings are latched here.
               if (!step_level) begin
                  par_check_in  = check_on;
                  tick_count_in = TICK_FIRST;
                  bits_left_in  = BITS_DATA + uart_rxop_pkg::BITS_W'(check_on);
                  shift_data_in = '0;
                  bit_select_in = uart_rxop_pkg::SEL_W'(1);
                  parity_acc_in = (parity_mode == uart_rxop_pkg::PARITY_ODD);
                  phase_in      = PH_DATA;
               end
            end
         endcase
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bits_left_ff  <= '0;
         shift_data_ff <= '0;
         bit_select_ff <= '0;
         parity_acc_ff <= 1'b0;
         par_check_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bits_left_ff  <= bits_left_in;
         shift_data_ff <= shift_data_in;
         bit_select_ff <= bit_select_in;
         parity_acc_ff <= parity_acc_in;
         par_check_ff  <= par_check_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/uart_rxop_outbuf.sv -----
// ----------------------------------------------------------------------------
// UART receiver output buffer
// Small queue of received bytes that drives the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rxop_outbuf (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire uart_rxop_pkg::result_type         push,
   output logic [uart_rxop_pkg::CNT_W-1:0]        count,
   uart_rxop_rsp_if.source                        rsp
);

   localparam logic [uart_rxop_pkg::PTR_W-1:0] PTR_LAST =
      uart_rxop_pkg::PTR_W'(uart_rxop_pkg::OUTBUF_DEPTH - 1);
   localparam logic [uart_rxop_pkg::PTR_W-1:0] PTR_ONE =
      uart_rxop_pkg::PTR_W'(1);
   localparam logic [uart_rxop_pkg::CNT_W-1:0] CNT_ONE =
      uart_rxop_pkg::CNT_W'(1);

   uart_rxop_pkg::byte_type              slot_ff [uart_rxop_pkg::OUTBUF_DEPTH];
   logic [uart_rxop_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [uart_rxop_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [uart_rxop_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                                 pop;

   assign pop               = rsp.valid && rsp.ready;
   assign rsp.valid         = (count_ff != '0);
   assign rsp.received_byte = slot_ff[rd_ptr_ff];
   assign count             = count_ff;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push.valid) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Byte storage; the top level never pushes into a full buffer.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/uart_rxop_checker.sv -----
// ----------------------------------------------------------------------------
// UART receiver port checker
// Port-level checks of the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_rx_oversampled_parity_unit_assert.svh"

module uart_rxop_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic [7:0]                rsp_received_byte
);

   // A byte offered on the response channel stays until it is taken.
   `URXOP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

   // A stalled byte keeps its value.
   `URXOP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_received_byte), "rsp byte changed")

   // Reset empties the output buffer.
   `URXOP_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

   // With nothing queued and no item in flight the receiver takes samples.
   `URXOP_ASSERT_NOW(a_req_free, clock, reset, !rsp_valid && !$past(req_valid && req_ready), req_ready, "ready low while empty")

endmodule

bind uart_rx_oversampled_parity_unit uart_rxop_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_received_byte (rsp_if.received_byte)
);

`default_nettype wire

// ----- bench/uart_rx_oversampled_parity_unit_tb.sv -----
// ----------------------------------------------------------------------------
// UART receiver testbench
// Drives line samples through the receiver: a table of frames, then random
// frames with noise. A bit-exact decoder model predicts untyped frames' bytes,
// typed rows carry their own; each received byte is compared with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uart_rx_oversampled_parity_unit_tb;

   localparam logic [uart_rxop_pkg::MODE_W-1:0] PARITY_UNUSED = 2'd3;
   localparam int MODE_KEEP      = -1;
   localparam int IDLE_PERCENT   = 23;
   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 4000;
   localparam int RANDOM_ITEMS   = 900;
   localparam int RANDOM_PHASES  = 6;

   typedef enum logic [1:0] {
      RX_IDLE = 2'd0,
      RX_DATA = 2'd1,
      RX_STOP = 2'd2
   } rx_phase_type;

   // One frame of stimulus; a typed row carries its own expected byte.
   typedef struct {
      int                      mode;
      uart_rxop_pkg::byte_type data;
      bit                      flip;
      int                      stop_lows;
      bit                      noisy;
      bit                      glitch;
      int                      switch_to;
      bit                      typed;
      bit                      want;
      uart_rxop_pkg::byte_type want_byte;
      int                      gap;
   } frame_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [uart_rxop_pkg::MODE_W-1:0] csr_write_data;

   uart_rxop_req_if req_ch ();
   uart_rxop_rsp_if rsp_ch ();

   uart_rx_oversampled_parity_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Tags that travel with each line sample.
   logic                    tag_typed;
   logic                    tag_want;
   logic                    tag_last;
   uart_rxop_pkg::byte_type tag_byte;

   // Values that the current frame puts on its tags.
   bit                      row_typed;
   bit                      row_want;
   uart_rxop_pkg::byte_type row_byte;

   // Decoder model state and its copy of the parity register.
   logic [uart_rxop_pkg::MODE_W-1:0] cfg_mode;
   rx_phase_type                     rx_phase;
   logic [uart_rxop_pkg::TICK_W-1:0] rx_ticks;
   logic [uart_rxop_pkg::BITS_W-1:0] rx_bits;
   uart_rxop_pkg::byte_type          rx_shift;
   logic [uart_rxop_pkg::SEL_W-1:0]  rx_select;
   logic                             rx_parity;
   logic                             rx_par_check;

   uart_rxop_pkg::byte_type expected_bytes [$];
   int  fail_count;
   int  stall_cycles;
   int  frame_items;
   bit  calm;
   bit  hold_pending;

   frame_row_type directed_rows [0:19] = '{
      '{uart_rxop_pkg::PARITY_NONE, 8'h00, 0, 0, 0, 0, MODE_KEEP, 1, 1, 8'h00, 2},
      '{MODE_KEEP,     8'hFF, 0, 0, 0, 0, MODE_KEEP,   1, 1, 8'hFF, 0},
      '{MODE_KEEP,     8'h80, 0, 0, 0, 0, MODE_KEEP,   1, 1, 8'h80, 3},
      '{MODE_KEEP,     8'h01, 0, 0, 0, 0, MODE_KEEP,   1, 1, 8'h01, 1},
      '{uart_rxop_pkg::PARITY_EVEN, 8'hA5, 0, 0, 0, 0, MODE_KEEP, 1, 1, 8'hA5, 2},
      '{MODE_KEEP,     8'hA5, 1, 0, 0, 0, MODE_KEEP,   1, 0, 8'h00, 2},
      '{MODE_KEEP,     8'h6E, 0, 0, 0, 0, MODE_KEEP,   0, 0, 8'h00, 2},
      '{uart_rxop_pkg::PARITY_ODD, 8'h01, 0, 0, 0, 0, MODE_KEEP, 1, 1, 8'h01, 2},
      '{MODE_KEEP,     8'h01, 1, 0, 0, 0, MODE_KEEP,   1, 0, 8'h00, 2},
      '{MODE_KEEP,     8'hFE, 0, 0, 0, 0, MODE_KEEP,   0, 0, 8'h00, 2},
      '{PARITY_UNUSED, 8'h5A, 0, 0, 0, 0, MODE_KEEP,   1, 1, 8'h5A, 2},
      '{uart_rxop_pkg::PARITY_NONE, 8'h3C, 0, 1, 0, 0, MODE_KEEP, 1, 1, 8'h3C, 2},
      '{MODE_KEEP,     8'hC3, 0, 2, 0, 0, MODE_KEEP,   1, 1, 8'hC3, 2},
      '{MODE_KEEP,     8'h00, 0, 4, 0, 0, MODE_KEEP,   1, 1, 8'h00, 2},
      '{MODE_KEEP,     8'h55, 0, 0, 1, 0, MODE_KEEP,   0, 0, 8'h00, 2},
      '{MODE_KEEP,     8'h00, 0, 0, 0, 1, MODE_KEEP,   0, 0, 8'h00, 40},
      '{MODE_KEEP, 8'hC3, 0, 0, 0, 0, uart_rxop_pkg::PARITY_EVEN, 1, 1, 8'hC3, 2},
      '{MODE_KEEP,     8'h0F, 0, 0, 0, 0, MODE_KEEP,   0, 0, 8'h00, 2},
      '{uart_rxop_pkg::PARITY_ODD, 8'hAA, 0, 0, 0, 0, uart_rxop_pkg::PARITY_NONE,
        0, 0, 8'h00, 2},
      '{MODE_KEEP,     8'h96, 0, 0, 1, 0, MODE_KEEP,   0, 0, 8'h00, 2}
   };

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Decoder model: takes a line sample, returns 1 on a byte with good parity.
   function automatic bit decode_line_sample(input logic level,
                                             output uart_rxop_pkg::byte_type rx_byte);
      rx_byte = '0;
      case (rx_phase)
         RX_DATA: begin
            rx_ticks = rx_ticks - 1'b1;
            if (rx_ticks == 0) begin
               rx_ticks = uart_rxop_pkg::TICK_W'(uart_rxop_pkg::TICKS_PER_BIT);
               if (level) begin
                  rx_shift[uart_rxop_pkg::DATA_BITS-1:0] =
                     rx_shift[uart_rxop_pkg::DATA_BITS-1:0] |
                     rx_select[uart_rxop_pkg::DATA_BITS-1:0];
                  rx_parity = ~rx_parity;
               end
               rx_select = rx_select << 1;
               rx_bits = rx_bits - 1'b1;
               if (rx_bits == 0) begin
                  rx_phase = RX_STOP;
               end
            end
            return 1'b0;
         end
         RX_STOP: begin
            rx_ticks = rx_ticks - 1'b1;
            if (rx_ticks == 0) begin
               rx_ticks = uart_rxop_pkg::TICK_W'(uart_rxop_pkg::TICKS_PER_BIT);
               if (level) begin
                  rx_phase = RX_IDLE;
                  if (rx_par_check && rx_parity) begin
                     return 1'b0;
                  end
                  rx_byte = rx_shift;
                  return 1'b1;
               end
            end
            return 1'b0;
         end
         default: begin
            rx_phase = RX_IDLE;
            if (!level) begin
               // The parity choice is latched here for the whole frame.
               rx_par_check = (cfg_mode == uart_rxop_pkg::PARITY_EVEN) ||
                              (cfg_mode == uart_rxop_pkg::PARITY_ODD);
               rx_ticks     = uart_rxop_pkg::TICK_W'(uart_rxop_pkg::FIRST_SAMPLE_TICKS);
               rx_bits      = uart_rxop_pkg::BITS_W'(uart_rxop_pkg::DATA_BITS) +
                              uart_rxop_pkg::BITS_W'(rx_par_check);
               rx_shift     = '0;
               rx_select    = uart_rxop_pkg::SEL_W'(1);
               rx_parity    = (cfg_mode == uart_rxop_pkg::PARITY_ODD);
               rx_phase     = RX_DATA;
            end
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input uart_rxop_pkg::byte_type got,
                                  input uart_rxop_pkg::byte_type want);
      $display("mismatch at %0t: %s, got %02h, want %02h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Predict on every accepted sample and check every accepted byte.
   always @(posedge clock) begin
      uart_rxop_pkg::byte_type model_byte;
      uart_rxop_pkg::byte_type want;
      bit                      model_has;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("byte with none expected", rsp_ch.received_byte, 8'h00);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.received_byte !== want) begin
                  report_mismatch("received_byte", rsp_ch.received_byte, want);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            model_has = decode_line_sample(req_ch.line_level, model_byte);
            if (tag_typed) begin
               if (tag_last && tag_want) begin
                  expected_bytes.push_back(tag_byte);
               end
            end else if (model_has) begin
               expected_bytes.push_back(model_byte);
            end
         end
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without progress", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Offer one line sample, with random idle cycles first, until accepted.
   task automatic send_item(input logic level, input logic last);
      while (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.line_level <= level;
      tag_typed         <= row_typed;
      tag_want          <= row_want;
      tag_byte          <= row_byte;
      tag_last          <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stop offering and wait until every predicted byte has arrived.
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [uart_rxop_pkg::MODE_W-1:0] mode);
      wait_drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_mode = mode;
   endtask

   task automatic send_idle(input int count);
      row_typed = 1'b0;
      repeat (count) send_item(1'b1, 1'b0);
   endtask

   // One frame: start bit, data LSB first, parity if latched, stop bits.
   // Each bit period is three samples, the final stop bit two; the second is decoded.
   task automatic send_frame(input frame_row_type row);
      logic periods [$];
      logic level;
      int   last_p;
      if (row.mode != MODE_KEEP) begin
         write_mode(row.mode[uart_rxop_pkg::MODE_W-1:0]);
      end
      row_typed = row.typed;
      row_want  = row.want;
      row_byte  = row.want_byte;
      if (row.glitch) begin
         // A single low sample starts a frame that then reads all ones.
         send_item(1'b0, 1'b0);
         frame_items++;
      end else begin
         periods.push_back(1'b0);
         for (int i = 0; i < uart_rxop_pkg::DATA_BITS; i++) begin
            periods.push_back(row.data[i]);
         end
         if ((cfg_mode == uart_rxop_pkg::PARITY_EVEN) ||
             (cfg_mode == uart_rxop_pkg::PARITY_ODD)) begin
            periods.push_back((^row.data) ^ (cfg_mode == uart_rxop_pkg::PARITY_ODD) ^
                              row.flip);
         end
         repeat (row.stop_lows) periods.push_back(1'b0);
         periods.push_back(1'b1);
         last_p = periods.size() - 1;
         for (int p = 0; p <= last_p; p++) begin
            // A register write in mid-frame must only count from the next frame.
            if ((row.switch_to != MODE_KEEP) && (p == 4)) begin
               write_mode(row.switch_to[uart_rxop_pkg::MODE_W-1:0]);
            end
            for (int t = 0; t < uart_rxop_pkg::TICKS_PER_BIT; t++) begin
               if (!((p == last_p) && (t == 2))) begin
                  if (p == 0) begin
                     level = (t == 0 || !row.noisy) ? 1'b0 : 1'($urandom_range(1));
                  end else begin
                     level = (t == 1 || !row.noisy) ? periods[p] : 1'($urandom_range(1));
                  end
                  send_item(level, (p == last_p) && (t == 1));
                  frame_items++;
               end
            end
         end
      end
      send_idle(row.gap);
   endtask

   // Random frame: mostly well-formed, some with bad parity or long stop.
   task automatic send_random_frame(input int gap);
      frame_row_type row;
      row.mode      = MODE_KEEP;
      row.data      = uart_rxop_pkg::byte_type'($urandom_range(255));
      row.flip      = ($urandom_range(99) < 15);
      row.stop_lows = ($urandom_range(99) < 15) ? $urandom_range(2, 1) : 0;
      row.noisy     = ($urandom_range(99) < 30);
      row.glitch    = 1'b0;
      row.switch_to = MODE_KEEP;
      row.typed     = 1'b0;
      row.want      = 1'b0;
      row.want_byte = '0;
      row.gap       = gap;
      send_frame(row);
   endtask

   // Main sequence.
   initial begin
      logic [uart_rxop_pkg::MODE_W-1:0] phase_modes [RANDOM_PHASES];
      int phase_goal;
      phase_modes = '{uart_rxop_pkg::PARITY_ODD, uart_rxop_pkg::PARITY_EVEN,
                      uart_rxop_pkg::PARITY_NONE, PARITY_UNUSED,
                      uart_rxop_pkg::PARITY_EVEN, uart_rxop_pkg::PARITY_ODD};
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.line_level = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      tag_typed         = 1'b0;
      tag_want          = 1'b0;
      tag_last          = 1'b0;
      tag_byte          = '0;
      row_typed         = 1'b0;
      row_want          = 1'b0;
      row_byte          = '0;
      fail_count        = 0;
      stall_cycles      = 0;
      frame_items       = 0;
      calm              = 1'b0;
      hold_pending      = 1'b0;
      cfg_mode          = uart_rxop_pkg::PARITY_NONE;
      rx_phase          = RX_IDLE;
      rx_ticks          = '0;
      rx_bits           = '0;
      rx_shift          = '0;
      rx_select         = '0;
      rx_parity         = 1'b0;
      rx_par_check      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed frames.
      foreach (directed_rows[i]) begin
         send_frame(directed_rows[i]);
      end

      // Random frames in phases, one parity setting per phase.
      frame_items = 0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_mode((ph < 4) ? phase_modes[ph] :
                    uart_rxop_pkg::MODE_W'($urandom_range(3)));
         calm = (ph == 2);
         if (ph == 3) begin
            // Output held off while frames arrive back to back.
            hold_pending = 1'b1;
            repeat (10) send_random_frame(0);
         end
         phase_goal = (ph + 1) * RANDOM_ITEMS / RANDOM_PHASES;
         while (frame_items < phase_goal) begin
            if ($urandom_range(99) < 10) begin
               // Noise burst, then enough idle line to fall back to idle.
               row_typed = 1'b0;
               repeat ($urandom_range(40, 5)) send_item(1'($urandom_range(1)), 1'b0);
               send_idle(40);
            end else begin
               send_random_frame(($urandom_range(99) < 30) ? 0 : $urandom_range(6));
            end
         end
      end
      calm = 1'b0;

      wait_drain();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
